>>> rtl/core/som_pkg.sv
`timescale 1ns / 1ps
// Package for the slice owner map allocator: sizes, codes, payload and
// owner entry types. No dependencies.
package som_pkg;

    localparam int MAX_SLICES  = 4096;
    localparam int NUM_VOLUMES = 16;

    localparam int SLICE_W   = 12;
    localparam int VOL_W     = 4;
    localparam int TOTAL_W   = 13;
    localparam int CNT_W     = $clog2(MAX_SLICES) + 1;
    localparam int ADDR_W    = $clog2(MAX_SLICES);
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int LFSR_W    = 32;
    localparam int ENTRY_W   = VOL_W + 1;

    localparam logic [LFSR_W-1:0]  SEED_DEFAULT  = 32'd44257;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS     = 32'hD000_0001;
    localparam logic [TOTAL_W-1:0] TOTAL_DEFAULT = 13'd4096;

    typedef enum logic [1:0] {
        REQ_ASSIGN = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_ALLOC  = 2'd2,
        REQ_NOP    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_ALREADY = 2'd2,
        STAT_NOFREE  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL = 1'd0,
        CFG_SEED  = 1'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP,
        S_RMW,
        S_DRAW,
        S_CHECK
    } state_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [SLICE_W-1:0] slice_index;
        logic [VOL_W-1:0]   volume;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLICE_W-1:0] chosen_slice;
    } rsp_t;

    typedef struct packed {
        logic             owned;
        logic [VOL_W-1:0] vol;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> rtl/core/som_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module som_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 5,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/som_lfsr.sv
`timescale 1ns / 1ps
// Random draw generator: 32-bit Galois LFSR with seed load.
// Depends on som_pkg.
module som_lfsr (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [som_pkg::LFSR_W-1:0]  seed,
    input  logic                        step,
    output logic [som_pkg::LFSR_W-1:0]  next_val
);
    import som_pkg::*;

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;

    assign next_val = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (load)
        begin
            lfsr_next = (seed == '0) ? SEED_DEFAULT : seed;
        end
        else if (step)
        begin
            lfsr_next = next_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_DEFAULT;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

>>> rtl/core/som_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: read-modify-write of the owner table, draw loop,
// owned count, total register and result register. Depends on som_pkg.
module som_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [som_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [som_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  som_pkg::req_t                  in_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output som_pkg::rsp_t                  out_rsp,
    output logic                           lfsr_step,
    input  logic [som_pkg::LFSR_W-1:0]     lfsr_next,
    output som_pkg::mem_req_t              mem,
    input  som_pkg::entry_t                ram_rdata
);
    import som_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]    owned_count_reg, owned_count_next;
    req_t                req_reg, req_next;
    logic [SLICE_W-1:0]  draw_reg, draw_next;
    rsp_t                pend_rsp_reg, pend_rsp_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_rsp_reg, out_rsp_next;

    logic [TOTAL_W-1:0]  eff_total;
    logic                slot_free;
    logic                post;
    rsp_t                post_rsp;
    logic                in_range;
    logic                vol_ok;
    logic [SLICE_W-1:0]  draw;

    assign eff_total = (total_reg >= TOTAL_W'(MAX_SLICES)) ? TOTAL_W'(MAX_SLICES) : total_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_range  = {1'b0, in_req.slice_index} < eff_total;
    assign vol_ok    = (in_req.req_type != REQ_ASSIGN) ||
                       ({1'b0, in_req.volume} < (VOL_W + 1)'(NUM_VOLUMES));
    assign draw      = lfsr_next[SLICE_W-1:0];

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        total_next       = total_reg;
        owned_count_next = owned_count_reg;
        req_next         = req_reg;
        draw_next        = draw_reg;
        pend_rsp_next    = pend_rsp_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_rsp_next     = out_rsp_reg;
        post             = 1'b0;
        post_rsp         = '{status: STAT_OK, chosen_slice: '0};
        mem              = '0;
        lfsr_step        = 1'b0;
        in_ready         = (state_reg == S_IDLE);

        if (cfg_we && (cfg_index == CFG_TOTAL))
        begin
            total_next = cfg_wdata[TOTAL_W-1:0];
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem.we       = 1'b1;
                mem.waddr    = clr_cnt_reg;
                mem.wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_req;
                    case (in_req.req_type) inside
                        REQ_ASSIGN, REQ_FREE:
                        begin
                            if (in_range && vol_ok)
                            begin
                                mem.re     = 1'b1;
                                mem.raddr  = in_req.slice_index;
                                state_next = S_RMW;
                            end
                            else
                            begin
                                pend_rsp_next = '{status: STAT_RANGE, chosen_slice: '0};
                                state_next    = S_RESP;
                            end
                        end
                        REQ_ALLOC:
                        begin
                            if (owned_count_reg >= eff_total)
                            begin
                                pend_rsp_next = '{status: STAT_NOFREE, chosen_slice: '0};
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DRAW;
                            end
                        end
                        default:
                        begin
                            pend_rsp_next = '{status: STAT_OK, chosen_slice: '0};
                            state_next    = S_RESP;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    post       = 1'b1;
                    post_rsp   = pend_rsp_reg;
                    state_next = S_IDLE;
                end
            end
            S_RMW:
            begin
                if (slot_free)
                begin
                    post       = 1'b1;
                    state_next = S_IDLE;
                    mem.waddr  = req_reg.slice_index;
                    if (req_reg.req_type == REQ_ASSIGN)
                    begin
                        if (ram_rdata.owned)
                        begin
                            post_rsp.status = STAT_ALREADY;
                        end
                        else
                        begin
                            mem.we           = 1'b1;
                            mem.wdata        = '{owned: 1'b1, vol: req_reg.volume};
                            owned_count_next = owned_count_reg + CNT_W'(1);
                        end
                    end
                    else if (ram_rdata.owned)
                    begin
                        mem.we    = 1'b1;
                        mem.wdata = '0;
                        if (owned_count_reg != '0)
                        begin
                            owned_count_next = owned_count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            S_DRAW:
            begin
                lfsr_step = 1'b1;
                if ({1'b0, draw} < eff_total)
                begin
                    mem.re     = 1'b1;
                    mem.raddr  = draw;
                    draw_next  = draw;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ram_rdata.owned)
                begin
                    state_next = S_DRAW;
                end
                else if (slot_free)
                begin
                    post                  = 1'b1;
                    post_rsp.chosen_slice = draw_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (post)
        begin
            out_valid_next = 1'b1;
            out_rsp_next   = post_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            total_reg       <= TOTAL_DEFAULT;
            owned_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            total_reg       <= total_next;
            owned_count_reg <= owned_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        draw_reg     <= draw_next;
        pend_rsp_reg <= pend_rsp_next;
        out_rsp_reg  <= out_rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owned_count_reg <= CNT_W'(MAX_SLICES))
        else $error("owned count exceeds slice capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (owned_count_reg != $past(owned_count_reg)) |->
            ($past(state_reg) == S_RMW) &&
            ((owned_count_reg == $past(owned_count_reg) + CNT_W'(1)) ||
             (owned_count_reg == $past(owned_count_reg) - CNT_W'(1))))
        else $error("owned count moved outside a table update");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_rsp_reg.status != STAT_OK)) |->
            (out_rsp_reg.chosen_slice == '0))
        else $error("failed transaction carries a slice number");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ({1'b0, draw_reg} < eff_total))
        else $error("checked draw lies outside the active slices");

endmodule

>>> rtl/core/slice_owner_map_allocator.sv
`timescale 1ns / 1ps
// Top level of the slice owner map allocator.
// Depends on som_pkg, som_ram, som_lfsr, som_ctrl.
//
// One request is in flight at a time. Assign and free first read the owner
// entry, then check it and write it back. Out-of-range, no-free-slice and
// no-op requests answer through a response state without a table access. A
// random allocation steps the LFSR on each draw; a draw at or above the total
// is skipped (LFSR step only), and a draw below it also starts a table read,
// followed by the owned check. The number of draws depends on how full the
// table is, and the single table read port sets the pace of the checks. A
// finished result waits in an output register while the next request is
// accepted. After reset the block sweeps the owner table to free, one entry a
// cycle, with in_ready low; configuration writes are taken throughout.
module slice_owner_map_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [som_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [som_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  som_pkg::req_t                  in_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output som_pkg::rsp_t                  out_rsp
);
    import som_pkg::*;

    mem_req_t          mem;
    entry_t            ram_rdata;
    logic [ENTRY_W-1:0] rdata_bits;
    logic              lfsr_step;
    logic [LFSR_W-1:0] lfsr_next;
    logic              seed_load;

    assign seed_load = cfg_we && (cfg_index == CFG_SEED);
    assign ram_rdata = entry_t'(rdata_bits);

    som_ram #(
        .DEPTH  (MAX_SLICES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .re    (mem.re),
        .raddr (mem.raddr),
        .rdata (rdata_bits)
    );

    som_lfsr u_lfsr (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (seed_load),
        .seed     (cfg_wdata),
        .step     (lfsr_step),
        .next_val (lfsr_next)
    );

    som_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp),
        .lfsr_step (lfsr_step),
        .lfsr_next (lfsr_next),
        .mem       (mem),
        .ram_rdata (ram_rdata)
    );

endmodule
